### sv/mma_pkg.sv
// shared types, widths and defaults for the multichannel moving average
package mma_pkg;

  localparam int TS_W           = 32;
  localparam int SAMPLE_W       = 16;
  localparam int CFG_W          = 5;
  localparam int WIN_REG_MAX    = (2 ** CFG_W) - 1;
  localparam int LEN_RST_VAL    = 16;
  localparam int CHANNELS_DEF   = 4;
  localparam int MAX_WINDOW_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE
  } state_t;

  // per-item control broadcast from the sequencer to every lane
  typedef struct packed {
    logic load;    // capture the lane's sample
    logic rd;      // read the oldest slot
    logic upd;     // write the new sample and update the running sum
    logic start;   // launch the divider
    logic clr;     // window length written: drop the running sum
    logic old_ok;  // the slot being replaced holds a written sample
  } lane_ctrl_t;

endpackage

### sv/mma_div.sv
// bit-serial signed by unsigned divider, quotient truncated toward zero
module mma_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 5,
  parameter int Q_W   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output logic                    done,
  output logic        [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   shift;
  logic             ge;
  logic [DEN_W:0]   diff;
  logic [NUM_W-1:0] quot_full;

  assign shift = {rem_r, q_r[NUM_W-1]};
  assign ge    = (shift >= {1'b0, den_r});
  assign diff  = shift - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      // magnitude; the most negative value maps onto itself as unsigned
      q_r   <= num[NUM_W-1] ? (-num) : num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= diff[DEN_W-1:0];
      end else begin
        rem_r <= shift[DEN_W-1:0];
      end
      q_r <= {q_r[NUM_W-2:0], ge};
    end
  end

  assign quot_full = neg_r ? (-q_r) : q_r;
  assign quot      = quot_full[Q_W-1:0];
  assign done      = done_r;

endmodule

### sv/mma_lane.sv
// one channel lane: sample ring, running sum and divider
module mma_lane #(
  parameter int DEPTH = 16,
  parameter int PTR_W = 4,
  parameter int SUM_W = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mma_pkg::lane_ctrl_t           ctrl,
  input  logic [PTR_W-1:0]              slot,
  input  logic [mma_pkg::SAMPLE_W-1:0]  sample,
  input  logic [mma_pkg::CFG_W-1:0]     len,
  output logic                          done,
  output logic [mma_pkg::SAMPLE_W-1:0]  avg
);
  import mma_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] smp_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SUM_W-1:0]    sum_r;

  logic [SAMPLE_W-1:0] old;
  logic [SUM_W-1:0]    sum_nxt;

  assign old     = ctrl.old_ok ? rd_data_r : '0;
  assign sum_nxt = sum_r
                 + {{(SUM_W-SAMPLE_W){smp_r[SAMPLE_W-1]}}, smp_r}
                 - {{(SUM_W-SAMPLE_W){old[SAMPLE_W-1]}}, old};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      smp_r <= sample;
    end
    if (ctrl.rd) begin
      rd_data_r <= mem[slot];
    end
    if (ctrl.upd) begin
      mem[slot] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      sum_r <= '0;
    end else if (ctrl.upd) begin
      sum_r <= sum_nxt;
    end
  end

  mma_div #(
    .NUM_W (SUM_W),
    .DEN_W (CFG_W),
    .Q_W   (SAMPLE_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl.start),
    .num   (signed'(sum_r)),
    .den   (len),
    .done  (done),
    .quot  (avg)
  );

endmodule

### sv/multichannel_moving_average.sv
// Multichannel boxcar moving average: sequencer, channel lanes and result merge.
// Items are taken one at a time: a new item is accepted only after the previous
// result is loaded into the output register; the bit-serial divider in each lane
// yields one quotient bit per cycle, and all lanes run side by side.
// Reset: controller idle, ring rows marked unwritten (read as zero), sums and
// write pointer zero, window length 16; no clearing pass, ready right after reset.
module multichannel_moving_average #(
  parameter int CHANNELS   = mma_pkg::CHANNELS_DEF,
  parameter int MAX_WINDOW = mma_pkg::MAX_WINDOW_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // time_stamp, sample_0 .. sample_{CHANNELS-1}
  input  logic [mma_pkg::TS_W+CHANNELS*mma_pkg::SAMPLE_W-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // time_stamp_out, average_0 .. average_{CHANNELS-1}
  output logic [mma_pkg::TS_W+CHANNELS*mma_pkg::SAMPLE_W-1:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [mma_pkg::CFG_W-1:0] cfg_data
);
  import mma_pkg::*;

  localparam int WIN_CAP = (MAX_WINDOW < WIN_REG_MAX) ? MAX_WINDOW : WIN_REG_MAX;
  localparam int PTR_W   = $clog2(WIN_CAP);
  localparam int SUM_W   = SAMPLE_W + $clog2(WIN_CAP);
  localparam int DATA_W  = TS_W + CHANNELS * SAMPLE_W;
  localparam int CMP_W   = CFG_W + 1;
  localparam logic [CFG_W-1:0] LEN_RST =
    CFG_W'((LEN_RST_VAL > WIN_CAP) ? WIN_CAP : LEN_RST_VAL);

  function automatic logic [CFG_W-1:0] sat_len(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (int'(v) > WIN_CAP) begin
      r = CFG_W'(WIN_CAP);
    end
    return r;
  endfunction

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    len_r;
  logic [PTR_W-1:0]    ptr_r;
  logic [WIN_CAP-1:0]  row_vld_r;
  logic [TS_W-1:0]     ts_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [DATA_W-1:0]   out_data_nxt;

  lane_ctrl_t          lane_ctrl;
  logic                in_accept;
  logic                cfg_accept;
  logic                out_load;
  logic                all_done;
  logic [CMP_W-1:0]    ptr_inc;
  logic [CHANNELS-1:0] lane_done;
  logic [SAMPLE_W-1:0] lane_avg [CHANNELS];

  assign in_accept  = in_tvalid && in_tready;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign all_done   = &lane_done;
  assign ptr_inc    = CMP_W'(ptr_r) + CMP_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_accept) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_START;
      ST_START:  state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready        = 1'b0;
    cfg_ready        = 1'b0;
    out_load         = 1'b0;
    lane_ctrl        = '0;
    lane_ctrl.clr    = cfg_accept;
    lane_ctrl.old_ok = row_vld_r[ptr_r];
    case (state_r)
      ST_IDLE: begin
        in_tready      = 1'b1;
        cfg_ready      = 1'b1;
        lane_ctrl.load = in_accept;
      end
      ST_READ:   lane_ctrl.rd    = 1'b1;
      ST_UPDATE: lane_ctrl.upd   = 1'b1;
      ST_START:  lane_ctrl.start = 1'b1;
      ST_DIVIDE: out_load = all_done && (!out_valid_r || out_tready);
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LEN_RST;
      ptr_r       <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_accept) begin
        len_r     <= sat_len(cfg_data);
        ptr_r     <= '0;
        row_vld_r <= '0;
      end else if (in_accept) begin
        if (CMP_W'(ptr_r) >= CMP_W'(len_r)) begin
          ptr_r <= '0;
        end
      end else if (lane_ctrl.upd) begin
        row_vld_r[ptr_r] <= 1'b1;
        if (ptr_inc >= CMP_W'(len_r)) begin
          ptr_r <= '0;
        end else begin
          ptr_r <= ptr_inc[PTR_W-1:0];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ts_r <= in_tdata[TS_W-1:0];
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    mma_lane #(
      .DEPTH (WIN_CAP),
      .PTR_W (PTR_W),
      .SUM_W (SUM_W)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lane_ctrl),
      .slot   (ptr_r),
      .sample (in_tdata[TS_W+c*SAMPLE_W +: SAMPLE_W]),
      .len    (len_r),
      .done   (lane_done[c]),
      .avg    (lane_avg[c])
    );
  end

  // merge the lane averages behind the timestamp
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[TS_W-1:0] = ts_r;
    for (int c = 0; c < CHANNELS; c++) begin
      out_data_nxt[TS_W+c*SAMPLE_W +: SAMPLE_W] = lane_avg[c];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_READ))
    else $error("accepted item did not start the sequence");

  a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(ptr_r) < CMP_W'(len_r))
    else $error("write pointer outside the window");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) && (int'(len_r) <= WIN_CAP))
    else $error("window length out of range");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE) |-> ((&lane_done) == (|lane_done)))
    else $error("lane dividers out of step");

  a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_ctrl.upd && !cfg_accept) |=> row_vld_r[$past(ptr_r)])
    else $error("written ring row not marked valid");

endmodule

### tb/sv/multichannel_moving_average_tb.sv
// self-checking testbench for the multichannel moving average
`timescale 1ns / 100ps

module multichannel_moving_average_tb;

  localparam int CH         = mma_pkg::CHANNELS_DEF;
  localparam int MAXW       = mma_pkg::MAX_WINDOW_DEF;
  localparam int SW         = mma_pkg::SAMPLE_W;
  localparam int RAND_ITEMS = 1326;
  localparam int HOLD_LEN   = 400;
  localparam int QUIET_MAX  = 3000;
  localparam int TAIL_WAIT  = 60;

  typedef struct packed {
    logic [CH-1:0][SW-1:0]     smp;
    logic [mma_pkg::TS_W-1:0]  ts;
  } meas_in_t;

  typedef struct packed {
    logic [CH-1:0][SW-1:0]     avg;
    logic [mma_pkg::TS_W-1:0]  ts;
  } meas_out_t;

  typedef struct {
    int                win;    // window write ahead of the row, -1 for none
    int                reps;
    logic [31:0]       ts;
    logic [CH*SW-1:0]  smp;    // sample_0 in the low bits
    bit                typed;
    logic [CH*SW-1:0]  avg;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [mma_pkg::TS_W+CH*SW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [mma_pkg::TS_W+CH*SW-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [mma_pkg::CFG_W-1:0] cfg_data;

  // averager state mirrored on the bench side
  int ring [CH][MAXW];
  int run_sum [CH];
  int ring_pos;
  int win_len;

  meas_out_t pending_averages [$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit long_hold = 1'b0;

  dir_row_t dir_tab [8] = '{
    '{-1, 1, 32'h0000_0000, 64'h0, 1, 64'h0},
    '{-1, 1, 32'hFFFF_FFFF, {16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF}, 1,
      {16'h0000, 16'h0000, 16'hF800, 16'h07FF}},
    '{0, 1, 32'h1234_5678, {16'h0005, 16'hFFFF, 16'h8000, 16'h7FFF}, 1,
      {16'h0005, 16'hFFFF, 16'h8000, 16'h7FFF}},
    '{-1, 1, 32'h8000_0000, {16'hFFF0, 16'h0010, 16'hAAAA, 16'h5555}, 1,
      {16'hFFF0, 16'h0010, 16'hAAAA, 16'h5555}},
    '{31, 1, 32'h0000_0001, {16'h0011, 16'hFFEF, 16'h8000, 16'h7FFF}, 1,
      {16'h0001, 16'hFFFF, 16'hF800, 16'h07FF}},
    // fills the whole ring with extremes: sums reach both ends
    '{-1, 16, 32'h4000_0000, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 0, 64'h0},
    '{16, 1, 32'hDEAD_BEEF, {16'hFFF1, 16'h000F, 16'hFF60, 16'h00A0}, 1,
      {16'h0000, 16'h0000, 16'hFFF6, 16'h000A}},
    '{3, 2, 32'h0000_0100, {16'h0123, 16'hFEDC, 16'h7FFF, 16'h8000}, 0, 64'h0}
  };

  multichannel_moving_average uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return SW'($signed($urandom_range(0, 40)) - 20);
      default: return SW'($urandom);
    endcase
  endfunction

  // a window write saturates into 1..MAXW and empties every ring
  function automatic void reload_window(input int val);
    win_len = (val == 0) ? 1 : (val > MAXW) ? MAXW : val;
    ring_pos = 0;
    for (int c = 0; c < CH; c++) begin
      run_sum[c] = 0;
      for (int k = 0; k < MAXW; k++) ring[c][k] = 0;
    end
  endfunction

  function automatic meas_out_t predict_averages(input meas_in_t m);
    meas_out_t r;
    int s;
    r.ts = m.ts;
    if (ring_pos >= win_len) ring_pos = 0;
    for (int c = 0; c < CH; c++) begin
      s = $signed(m.smp[c]);
      run_sum[c] = run_sum[c] + s - ring[c][ring_pos];
      ring[c][ring_pos] = s;
      r.avg[c] = SW'(run_sum[c] / win_len);
    end
    ring_pos = (ring_pos + 1 >= win_len) ? 0 : ring_pos + 1;
    return r;
  endfunction

  task automatic send_item(input meas_in_t item, input bit typed,
                           input logic [CH*SW-1:0] typed_avg);
    int gap;
    meas_out_t pred;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= item;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pred = predict_averages(item);
    if (typed) pred.avg = typed_avg;
    pending_averages.push_back(pred);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_averages.size() != 0);
  endtask

  task automatic write_window(input int val);
    cfg_data  <= mma_pkg::CFG_W'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    reload_window(val);
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        gap = HOLD_LEN;
        long_hold = 1'b0;
      end else begin
        gap = draw_gap();
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    meas_out_t got;
    meas_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_averages.size() == 0) begin
        $error("result with ts %0h arrived with nothing expected", got.ts);
        mismatch_count++;
      end else begin
        want = pending_averages.pop_front();
        check_field("time_stamp_out", longint'(want.ts), longint'(got.ts));
        for (int c = 0; c < CH; c++)
          check_field($sformatf("average_%0d", c), longint'($signed(want.avg[c])),
                      longint'($signed(got.avg[c])));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int win_plan [8];
    meas_in_t item;
    int rand_sent;
    int phase;
    int n;
    win_plan = '{1, 0, 31, 17, 2, 15, 16, 3};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    reload_window(mma_pkg::LEN_RST_VAL);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].win >= 0) begin
        drain_results();
        write_window(dir_tab[i].win);
      end
      for (int k = 0; k < dir_tab[i].reps; k++) begin
        item.ts  = dir_tab[i].ts + k;
        item.smp = dir_tab[i].smp;
        send_item(item, dir_tab[i].typed, dir_tab[i].avg);
      end
    end

    rand_sent = 0;
    phase = 0;
    while (rand_sent < RAND_ITEMS) begin
      n = (phase == 3) ? 60 : $urandom_range(10, 60);
      drain_results();
      calm = (phase == 3) || ($urandom_range(0, 4) == 0);
      write_window((phase < 8) ? win_plan[phase] : $urandom_range(0, 31));
      // back up the result side so the input has to stall
      if (phase == 3) long_hold = 1'b1;
      repeat (n) begin
        item.ts = $urandom;
        for (int c = 0; c < CH; c++) item.smp[c] = rand_sample();
        send_item(item, 1'b0, '0);
      end
      rand_sent += n;
      phase++;
    end

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_averages.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### multichannel_moving_average.f
sv/mma_pkg.sv
sv/mma_div.sv
sv/mma_lane.sv
sv/multichannel_moving_average.sv
tb/sv/multichannel_moving_average_tb.sv
